### rtl/core/mpsr_pkg.sv
`default_nettype none

package mpsr_pkg;

	// command codes carried in the action field
	typedef enum logic [2:0] {
		ACT_PAT_BYTE = 3'd0,
		ACT_REP_BYTE = 3'd1,
		ACT_PAT_LEN  = 3'd2,
		ACT_REP_LEN  = 3'd3,
		ACT_DATA     = 3'd4,
		ACT_END      = 3'd5
	} mpsr_action_t;

	// one input item
	typedef struct packed {
		logic [2:0] action;
		logic [2:0] entry_index;
		logic [3:0] byte_position;
		logic [7:0] value;
	} mpsr_cmd_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       hit;
		logic [2:0] hit_entry;
		logic       last;
	} mpsr_res_t;

	// table load broadcast to every cell
	typedef struct packed {
		logic       pat_we;
		logic       rep_we;
		logic [2:0] entry;
		logic [3:0] pos;
		logic [7:0] byte_val;
	} mpsr_load_t;

	// window control broadcast to every cell
	typedef struct packed {
		logic       emit;
		logic       append;
		logic       all_live;
		logic [7:0] data;
	} mpsr_win_ctl_t;

endpackage

`default_nettype wire

### rtl/core/mpsr_cell.sv
`default_nettype none

module mpsr_cell
	import mpsr_pkg::*;
#(
	parameter int POS         = 0,
	parameter int MAX_ENTRIES = 8,
	parameter int MAX_LEN     = 16,
	localparam int LW         = $clog2(MAX_LEN + 1)
) (
	input  wire logic                   clk,
	input  wire mpsr_load_t             ld,
	input  wire mpsr_win_ctl_t          ctl,
	input  wire logic [LW-1:0]          fill,
	input  wire logic [LW-1:0]          plen [MAX_ENTRIES],
	input  wire logic [LW-1:0]          rlen [MAX_ENTRIES],
	input  wire logic [MAX_ENTRIES-1:0] sel,
	input  wire logic [7:0]             nb_byte,
	output logic [MAX_ENTRIES-1:0]      match,
	output logic [7:0]                  cur_byte
);

	logic [7:0] win_q;
	logic [7:0] pat_q [MAX_ENTRIES];
	logic [7:0] rep_q [MAX_ENTRIES];
	logic       live;
	logic       is_tail;

	assign live    = ctl.all_live || (POS < 32'(fill));
	assign is_tail = (32'(fill) == POS);

	// pattern and replacement bytes for this offset, one per entry
	always_ff @(posedge clk) begin
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			if (ld.pat_we && 32'(ld.entry) == e && 32'(ld.pos) == POS) begin
				pat_q[e] <= ld.byte_val;
			end
			if (ld.rep_we && 32'(ld.entry) == e && 32'(ld.pos) == POS) begin
				rep_q[e] <= ld.byte_val;
			end
		end
	end

	// window byte: shift from neighbor on emit, or take new data at the tail
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			win_q <= nb_byte;
		end else if (ctl.append && is_tail) begin
			win_q <= ctl.data;
		end
	end

	// per-entry compare, offsets past the pattern length always agree
	always_comb begin
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			match[e] = (win_q == pat_q[e]) || !(POS < 32'(plen[e]));
		end
	end

	// overwrite with the selected replacement byte inside its length
	always_comb begin
		cur_byte = win_q;
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			if (sel[e] && live && POS < 32'(rlen[e])) begin
				cur_byte = rep_q[e];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/multi_pattern_stream_replacer_unit.sv
// Throughput: one item per cycle unless a drain or a stalled result holds it; compare, replace
// and shift of the whole cell row happen in the same cycle. A data byte that finds the window
// full gives its result in the cycle after it is taken. End of region drains the window at one
// result per cycle while res_stall is low, one per buffered byte, stalling the command channel
// until the last byte is emitted. Reset (arst_n low): window fill, lengths, active count and
// handshake state clear; window bytes and pattern/replacement tables are undefined until loaded.
`default_nettype none

module multi_pattern_stream_replacer_unit
	import mpsr_pkg::*;
#(
	parameter int MAX_ENTRIES = 8,
	parameter int MAX_LEN     = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [3:0] cfg_wdata,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire mpsr_cmd_t cmd,
	output logic           res_valid,
	input  wire logic      res_stall,
	output mpsr_res_t      res
);

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int AW = $clog2(MAX_ENTRIES + 1);

	logic [LW-1:0]          fill_q;
	logic                   drain_q;
	logic [AW-1:0]          act_q;
	logic [LW-1:0]          longest_q;
	logic [LW-1:0]          plen_q [MAX_ENTRIES];
	logic [LW-1:0]          rlen_q [MAX_ENTRIES];
	logic                   res_valid_q;
	mpsr_res_t              res_q;

	logic                   accept;
	logic                   free;
	logic                   is_pat_byte, is_rep_byte, is_pat_len, is_rep_len;
	logic                   is_data, is_end;
	logic                   emit_data, emit_drain, emit;
	logic                   test_en;
	logic [LW-1:0]          len_sat;
	logic [LW-1:0]          max_len_c;
	logic [MAX_ENTRIES-1:0] hit_vec;
	logic [MAX_ENTRIES-1:0] sel;
	logic [EW-1:0]          hit_idx;
	mpsr_load_t             ld;
	mpsr_win_ctl_t          ctl;
	logic [7:0]             cell_byte [MAX_LEN];
	logic [7:0]             nb_byte   [MAX_LEN];
	logic [MAX_ENTRIES-1:0] match     [MAX_LEN];

	// handshake: output register frees in the cycle it is taken
	assign free      = !res_valid_q || !res_stall;
	assign cmd_stall = drain_q || !free;
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// decode the accepted item
	always_comb begin
		is_pat_byte = 1'b0;
		is_rep_byte = 1'b0;
		is_pat_len  = 1'b0;
		is_rep_len  = 1'b0;
		is_data     = 1'b0;
		is_end      = 1'b0;
		unique case (cmd.action)
			ACT_PAT_BYTE: is_pat_byte = accept;
			ACT_REP_BYTE: is_rep_byte = accept;
			ACT_PAT_LEN:  is_pat_len  = accept;
			ACT_REP_LEN:  is_rep_len  = accept;
			ACT_DATA:     is_data     = accept;
			ACT_END:      is_end      = accept;
			default: ;
		endcase
	end

	assign emit_data  = is_data && (32'(fill_q) == MAX_LEN);
	assign emit_drain = drain_q && free;
	assign emit       = emit_data || emit_drain;
	assign test_en    = emit_data || (fill_q > longest_q);
	assign len_sat    = (32'(cmd.value) > MAX_LEN) ? LW'(MAX_LEN) : LW'(cmd.value);

	// broadcast buses to the cell row
	always_comb begin
		ld.pat_we    = is_pat_byte;
		ld.rep_we    = is_rep_byte;
		ld.entry     = cmd.entry_index;
		ld.pos       = cmd.byte_position;
		ld.byte_val  = cmd.value;
		ctl.emit     = emit;
		ctl.append   = is_data;
		ctl.all_live = emit_data;
		ctl.data     = cmd.value;
	end

	// cell row, each cell shifts toward the front on emit
	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		if (k == MAX_LEN - 1) begin : g_tail
			assign nb_byte[k] = cmd.value;
		end else begin : g_mid
			assign nb_byte[k] = cell_byte[k+1];
		end
		mpsr_cell #(
			.POS         (k),
			.MAX_ENTRIES (MAX_ENTRIES),
			.MAX_LEN     (MAX_LEN)
		) u_cell (
			.clk      (clk),
			.ld       (ld),
			.ctl      (ctl),
			.fill     (fill_q),
			.plen     (plen_q),
			.rlen     (rlen_q),
			.sel      (sel),
			.nb_byte  (nb_byte[k]),
			.match    (match[k]),
			.cur_byte (cell_byte[k])
		);
	end

	// full-pattern hit per entry
	always_comb begin
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			hit_vec[e] = test_en && (32'(act_q) > e);
			for (int k = 0; k < MAX_LEN; k++) begin
				hit_vec[e] = hit_vec[e] && match[k][e];
			end
		end
	end

	// lowest index wins
	always_comb begin
		sel     = '0;
		hit_idx = '0;
		for (int e = MAX_ENTRIES - 1; e >= 0; e--) begin
			if (hit_vec[e]) begin
				sel     = '0;
				sel[e]  = 1'b1;
				hit_idx = EW'(e);
			end
		end
	end

	// longest active pattern length
	always_comb begin
		max_len_c = '0;
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			if (32'(act_q) > e && plen_q[e] > max_len_c) begin
				max_len_c = plen_q[e];
			end
		end
	end

	// configuration, lengths and longest length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= '0;
			longest_q <= '0;
			for (int e = 0; e < MAX_ENTRIES; e++) begin
				plen_q[e] <= '0;
				rlen_q[e] <= '0;
			end
		end else begin
			if (cfg_we) begin
				act_q <= (32'(cfg_wdata) > MAX_ENTRIES) ? AW'(MAX_ENTRIES) : AW'(cfg_wdata);
			end
			longest_q <= max_len_c;
			for (int e = 0; e < MAX_ENTRIES; e++) begin
				if (is_pat_len && 32'(cmd.entry_index) == e) begin
					plen_q[e] <= len_sat;
				end
				if (is_rep_len && 32'(cmd.entry_index) == e) begin
					rlen_q[e] <= len_sat;
				end
			end
		end
	end

	// window fill and drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			drain_q <= 1'b0;
		end else begin
			if (is_data && !emit_data) begin
				fill_q <= fill_q + LW'(1);
			end else if (emit_drain) begin
				fill_q <= fill_q - LW'(1);
			end
			if (is_end && fill_q != '0) begin
				drain_q <= 1'b1;
			end else if (emit_drain && fill_q == LW'(1)) begin
				drain_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (free) begin
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (free && emit) begin
			res_q.out_byte  <= cell_byte[0];
			res_q.hit       <= |hit_vec;
			res_q.hit_entry <= 3'(hit_idx);
			res_q.last      <= emit_drain && (fill_q == LW'(1));
		end
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_LEN)
		else $error("window fill out of range");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> fill_q != '0)
		else $error("draining with empty window");

	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.last) |-> (fill_q == '0 && !drain_q))
		else $error("last marker while window still holds bytes");

	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.hit) |-> res_q.hit_entry == 3'd0)
		else $error("hit entry set without a hit");
`endif

endmodule

`default_nettype wire
